>>> src/tga_dec_pkg.sv
package tga_dec_pkg;

  localparam int CFG_AW = 4;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [7:0] REPEAT_BIAS = 8'd127;
  localparam logic [7:0] FULL_ALPHA = 8'd255;
  localparam logic [7:0] SINGLE_RUN = 8'd1;

  typedef enum logic [1:0] {
    REG_RLE_ENABLE,
    REG_FOUR_BPP,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } tga_reg_t;

  typedef struct packed {
    logic        rle_enable;
    logic        four_bpp;
    logic [31:0] total;
  } tga_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] lane;
    logic       pix_end;
    logic [7:0] run;
    logic       last;
  } tga_tok_t;

endpackage

>>> src/tga_dec_regs.sv
module tga_dec_regs
  import tga_dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tga_cfg_t          cfg,
  output logic              restart
);

  logic        rle_r;
  logic        four_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [31:0] total_r;
  logic [15:0] width_eff;
  logic [15:0] height_eff;
  logic [31:0] total_nxt;
  tga_reg_t    idx;

  assign pready = 1'b1;
  assign idx = tga_reg_t'(paddr[CFG_AW-1:2]);
  assign restart = psel && penable && pwrite;

  assign width_eff = (width_r == 16'd0) ? 16'd1 : width_r;
  assign height_eff = (height_r == 16'd0) ? 16'd1 : height_r;
  assign total_nxt = {16'd0, width_eff} * {16'd0, height_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_r    <= 1'b0;
      four_r   <= 1'b1;
      width_r  <= 16'd1;
      height_r <= 16'd1;
      total_r  <= 32'd1;
    end else begin
      total_r <= total_nxt;
      if (restart) begin
        unique case (idx)
          REG_RLE_ENABLE:   rle_r    <= pwdata[0];
          REG_FOUR_BPP:     four_r   <= pwdata[0];
          REG_IMAGE_WIDTH:  width_r  <= pwdata[15:0];
          REG_IMAGE_HEIGHT: height_r <= pwdata[15:0];
          default:          rle_r    <= rle_r;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_RLE_ENABLE:   prdata = {31'd0, rle_r};
      REG_FOUR_BPP:     prdata = {31'd0, four_r};
      REG_IMAGE_WIDTH:  prdata = {16'd0, width_r};
      REG_IMAGE_HEIGHT: prdata = {16'd0, height_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.rle_enable = rle_r;
  assign cfg.four_bpp = four_r;
  assign cfg.total = total_r;

endmodule

>>> src/tga_dec_front.sv
module tga_dec_front
  import tga_dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tga_cfg_t   cfg,
  input  logic       restart,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       q_full,
  output logic       q_push,
  output tga_tok_t   q_tok
);

  logic        rep_r;
  logic        rep_nxt;
  logic [7:0]  left_r;
  logic [7:0]  left_nxt;
  logic [1:0]  lane_r;
  logic [1:0]  lane_nxt;
  logic [31:0] remain_r;
  logic [31:0] remain_nxt;
  logic        reload_r;
  logic        reload_nxt;

  logic        accept;
  logic        is_hdr;
  logic        pix_end;
  logic [7:0]  run_raw;
  logic [7:0]  run_out;
  logic [31:0] rem;
  logic        last;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    is_hdr = cfg.rle_enable && (left_r == 8'd0);
    pix_end = (lane_r == 2'd3) || (!cfg.four_bpp && (lane_r == 2'd2));
    run_raw = (cfg.rle_enable && rep_r) ? left_r : SINGLE_RUN;
    rem = reload_r ? cfg.total : remain_r;
    last = (rem[31:8] == 24'd0) && (rem[7:0] <= run_raw);
    if (last) begin
      run_out = (rem[7:0] == 8'd0) ? SINGLE_RUN : rem[7:0];
    end else begin
      run_out = run_raw;
    end
  end

  always_comb begin
    rep_nxt = rep_r;
    left_nxt = left_r;
    lane_nxt = lane_r;
    remain_nxt = remain_r;
    reload_nxt = reload_r;
    priority if (restart) begin
      rep_nxt = 1'b0;
      left_nxt = 8'd0;
      lane_nxt = 2'd0;
      reload_nxt = 1'b1;
    end else if (accept && is_hdr) begin
      rep_nxt = in_data_byte[7];
      left_nxt = in_data_byte[7] ? (in_data_byte - REPEAT_BIAS) : (in_data_byte + 8'd1);
      lane_nxt = 2'd0;
    end else if (accept && !pix_end) begin
      lane_nxt = lane_r + 2'd1;
    end else if (accept) begin
      lane_nxt = 2'd0;
      if (last) begin
        rep_nxt = 1'b0;
        left_nxt = 8'd0;
        reload_nxt = 1'b1;
      end else begin
        remain_nxt = rem - {24'd0, run_raw};
        reload_nxt = 1'b0;
        if (cfg.rle_enable) begin
          left_nxt = rep_r ? 8'd0 : (left_r - 8'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r    <= 1'b0;
      left_r   <= 8'd0;
      lane_r   <= 2'd0;
      remain_r <= 32'd0;
      reload_r <= 1'b1;
    end else begin
      rep_r    <= rep_nxt;
      left_r   <= left_nxt;
      lane_r   <= lane_nxt;
      remain_r <= remain_nxt;
      reload_r <= reload_nxt;
    end
  end

  assign q_push = accept && !is_hdr && !restart;
  assign q_tok.data = in_data_byte;
  assign q_tok.lane = lane_r;
  assign q_tok.pix_end = pix_end;
  assign q_tok.run = run_out;
  assign q_tok.last = last;

endmodule

>>> src/tga_dec_fifo.sv
module tga_dec_fifo
  import tga_dec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tga_tok_t push_tok,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output tga_tok_t head_tok
);

  tga_tok_t      mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic [Q_AW:0]   count_nxt;
  logic            do_pop;

  assign full = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok = mem_r[rd_ptr_r];
  assign do_pop = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    unique case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

>>> src/tga_dec_back.sv
module tga_dec_back
  import tga_dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tga_cfg_t   cfg,
  input  logic       tok_valid,
  input  tga_tok_t   tok,
  output logic       tok_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic [7:0] out_run_length,
  output logic       out_last_pixel
);

  logic [31:0] gather_r;
  logic [31:0] merged;
  logic        out_valid_r;
  logic        load;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [7:0]  alpha_r;
  logic [7:0]  run_r;
  logic        last_r;

  always_comb begin
    merged = gather_r;
    unique case (tok.lane)
      2'd0:    merged[7:0] = tok.data;
      2'd1:    merged[15:8] = tok.data;
      2'd2:    merged[23:16] = tok.data;
      default: merged[31:24] = tok.data;
    endcase
  end

  assign tok_pop = tok_valid && (!tok.pix_end || !out_valid_r || out_ready);
  assign load = tok_pop && tok.pix_end;

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      gather_r <= merged;
    end
    if (load) begin
      red_r   <= merged[23:16];
      green_r <= merged[15:8];
      blue_r  <= merged[7:0];
      alpha_r <= cfg.four_bpp ? merged[31:24] : FULL_ALPHA;
      run_r   <= tok.run;
      last_r  <= tok.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red = red_r;
  assign out_green = green_r;
  assign out_blue = blue_r;
  assign out_alpha = alpha_r;
  assign out_run_length = run_r;
  assign out_last_pixel = last_r;

endmodule

>>> src/tga_rle_pixel_stream_decoder.sv
// A byte is taken in every cycle in which the four-entry queue behind the front end has room.
// A pixel's final byte is written into the queue and then loaded into the output register, from which the pixel leaves.
// The sustained rate is one byte per cycle, limited only by the output handshake.
// The synchronous active-low reset restores the register defaults, empties the queue,
// clears the output valid and starts a new image.
module tga_rle_pixel_stream_decoder
  import tga_dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  output logic [7:0]        out_run_length,
  output logic              out_last_pixel,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  tga_cfg_t cfg;
  logic     restart;
  logic     q_full;
  logic     q_push;
  tga_tok_t q_tok;
  logic     head_valid;
  tga_tok_t head_tok;
  logic     tok_pop;

  tga_dec_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  tga_dec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .restart      (restart),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tok        (q_tok)
  );

  tga_dec_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (q_tok),
    .full       (q_full),
    .pop        (tok_pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  tga_dec_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .tok_valid      (head_valid),
    .tok            (head_tok),
    .tok_pop        (tok_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_run_length (out_run_length),
    .out_last_pixel (out_last_pixel)
  );

endmodule

>>> src/tga_dec_chk.sv
module tga_dec_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        out_red,
  input logic [7:0]        out_green,
  input logic [7:0]        out_blue,
  input logic [7:0]        out_alpha,
  input logic [7:0]        out_run_length,
  input logic              out_last_pixel
);

  // A stalled result request keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha) && $stable(out_run_length)
      && $stable(out_last_pixel))
    else $error("result request changed while stalled");

  // Every run carries between one and the largest packet count of pixels.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_length != 8'd0) && (out_run_length <= 8'd128))
    else $error("run length out of range");

  // Reset leaves no result pending and an empty queue that takes bytes.
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("state not cleared by reset");

  // A run that is not the last of the image cannot exceed a single packet.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel && (out_run_length > 8'd1) |->
      (out_run_length <= 8'd128))
    else $error("repeat run malformed");

endmodule

bind tga_rle_pixel_stream_decoder tga_dec_chk u_chk (.*);
